// File: hw/rtl/cci_pkg.sv
`timescale 1ns / 1ps
package cci_pkg;

    localparam int CW    = 16;  // coordinate field width
    localparam int RW    = 15;  // radius field width
    localparam int DW    = 17;  // centre difference
    localparam int SQW   = 32;  // squared radius sum and difference
    localparam int D2W   = 34;  // squared centre distance
    localparam int KW    = 36;  // chord offset term
    localparam int PW    = 64;  // square root radicand
    localparam int ROOTW = PW / 2;
    localparam int REMW  = ROOTW + 3;
    localparam int NW    = 53;  // point numerators
    localparam int DENW  = D2W + 1;
    localparam int QW    = 18;  // quotient bits
    localparam int OFFW  = QW + 1;
    localparam int PTW   = 20;  // unsaturated point coordinate
    localparam int LANES = 4;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_CROSS,
        CLS_FIRST,
        CLS_SECOND
    } cls_t;

    typedef enum logic [1:0] {
        KIND_CROSS  = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_SECOND = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic [RW-1:0]        first_radius;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic [RW-1:0]        second_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic [1:0]           point_kind;
        logic                 last_point;
    } out_item_t;

    typedef struct packed {
        cls_t                 cls;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [RW-1:0]        cr;
    } ctr_t;

    typedef struct packed {
        logic signed [KW-1:0] k;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [D2W-1:0]       d2;
        ctr_t                 c;
    } sq_side_t;

    typedef struct packed {
        logic [DENW-1:0]  den;
        logic [LANES-1:0] neg;
        ctr_t             c;
    } dv_side_t;

    typedef struct packed {
        cls_t                       cls;
        logic [LANES-1:0][CW-1:0]   x;
        logic [LANES-1:0][CW-1:0]   y;
    } pt_item_t;

endpackage

// File: hw/rtl/cci_stream_if.sv
`timescale 1ns / 1ps
interface cci_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/cci_sqrt_cell.sv
`timescale 1ns / 1ps
module cci_sqrt_cell
    import cci_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [PW-1:0]    rad_in,
    input  logic [REMW-1:0]  rem_in,
    input  logic [ROOTW-1:0] root_in,
    output logic [PW-1:0]    rad_out,
    output logic [REMW-1:0]  rem_out,
    output logic [ROOTW-1:0] root_out
);

    logic [PW-1:0]    rad_reg, rad_next;
    logic [REMW-1:0]  rem_reg, rem_next;
    logic [ROOTW-1:0] root_reg, root_next;
    logic [REMW-1:0]  rem_sh, trial;
    logic             ge;

    // One root bit per cell: bring down two radicand bits and try root*4+1.
    always_comb
    begin
        rem_sh    = {rem_in[REMW-3:0], rad_in[PW-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = rem_sh >= trial;
        rem_next  = ge ? rem_sh - trial : rem_sh;
        root_next = {root_in[ROOTW-2:0], ge};
        rad_next  = {rad_in[PW-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: hw/rtl/cci_div_cell.sv
`timescale 1ns / 1ps
module cci_div_cell
    import cci_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [DENW-1:0] den,
    input  logic [DENW-1:0] rem_in,
    input  logic [QW-1:0]   bits_in,
    input  logic [QW-1:0]   q_in,
    output logic [DENW-1:0] rem_out,
    output logic [QW-1:0]   bits_out,
    output logic [QW-1:0]   q_out
);

    logic [DENW-1:0] rem_reg, rem_next;
    logic [QW-1:0]   bits_reg, bits_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [DENW:0]   t, diff;
    logic            ge;

    // Restoring division, one quotient bit per cell.
    always_comb
    begin
        t         = {rem_in, bits_in[QW-1]};
        diff      = t - {1'b0, den};
        ge        = t >= {1'b0, den};
        rem_next  = ge ? diff[DENW-1:0] : t[DENW-1:0];
        q_next    = {q_in[QW-2:0], ge};
        bits_next = {bits_in[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            q_reg    <= q_next;
        end
    end

    assign rem_out  = rem_reg;
    assign bits_out = bits_reg;
    assign q_out    = q_reg;

endmodule

// File: hw/rtl/cci_emit.sv
`timescale 1ns / 1ps
module cci_emit
    import cci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  pt_item_t item,
    output logic     take,
    cci_stream_if.source points
);

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    pt_item_t   hold_reg;
    logic       last;
    kind_t      kind;

    always_comb
    begin
        last = (hold_reg.cls == CLS_CROSS) ? (idx_reg == 2'd1) : (idx_reg == 2'd3);
        take = !busy_reg || (points.ready && last);
        case (hold_reg.cls)
            CLS_FIRST:  kind = KIND_FIRST;
            CLS_SECOND: kind = KIND_SECOND;
            default:    kind = KIND_CROSS;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = item_valid;
            idx_next  = 2'd0;
        end
        else if (points.ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            hold_reg <= item;
        end
    end

    always_comb
    begin
        points.valid           = busy_reg;
        points.data.point_x    = hold_reg.x[idx_reg];
        points.data.point_y    = hold_reg.y[idx_reg];
        points.data.point_kind = kind;
        points.data.last_point = last;
    end

endmodule

// File: hw/rtl/circle_circle_intersection.sv
`timescale 1ns / 1ps
// Throughput: one pair per cycle when the circles are disjoint and the output sequencer is idle;
// a crossing pair yields two points and a pair where one contains the other yields four, and
// the single output port sends one point per cycle while points.ready is high.
// Reset: asynchronous, clears the stage valid bits and the output sequencer only.
module circle_circle_intersection
    import cci_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    cci_stream_if.sink   circles,
    cci_stream_if.source points
);

    localparam int WORK_BITS = (COORD_BITS > CW) ? CW : COORD_BITS;
    localparam int SHIFT_W   = CW - WORK_BITS;
    localparam logic [RW-1:0] RAD_MASK = RW'((1 << (WORK_BITS - 1)) - 1);
    localparam logic [CW-1:0] OUT_MASK = CW'((1 << WORK_BITS) - 1);
    localparam logic signed [PTW-1:0] SAT_HI = PTW'((1 << (WORK_BITS - 1)) - 1);
    localparam logic signed [PTW-1:0] SAT_LO = PTW'(-(1 << (WORK_BITS - 1)));
    localparam int SQ_CELLS = ROOTW;
    localparam int NST      = 5 + SQ_CELLS + 4 + QW + 2;

    function automatic logic [CW-1:0] sat(input logic signed [PTW-1:0] v);
        logic signed [PTW-1:0] c;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return c[CW-1:0] & OUT_MASK;
    endfunction

    logic           adv;
    logic           take;
    logic [NST-1:0] vld_reg;
    logic           accept;

    assign accept       = circles.valid && circles.ready;
    assign circles.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], accept};
    end

    // Stage 1: field decode and centre differences.
    logic signed [CW-1:0] fx_w, fy_w, sx_w, sy_w, t_fx, t_fy, t_sx, t_sy;
    logic signed [CW-1:0] fx1, fy1, sx1, sy1;
    logic [RW-1:0]        r1_1, r2_1;
    logic signed [DW-1:0] dx1, dy1;
    logic [CW-1:0]        sum1;
    logic signed [CW-1:0] diff1;

    always_comb
    begin
        t_fx = circles.data.first_x <<< SHIFT_W;
        t_fy = circles.data.first_y <<< SHIFT_W;
        t_sx = circles.data.second_x <<< SHIFT_W;
        t_sy = circles.data.second_y <<< SHIFT_W;
        fx_w = t_fx >>> SHIFT_W;
        fy_w = t_fy >>> SHIFT_W;
        sx_w = t_sx >>> SHIFT_W;
        sy_w = t_sy >>> SHIFT_W;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx1   <= fx_w;
            fy1   <= fy_w;
            sx1   <= sx_w;
            sy1   <= sy_w;
            r1_1  <= circles.data.first_radius & RAD_MASK;
            r2_1  <= circles.data.second_radius & RAD_MASK;
            dx1   <= $signed({fx_w[CW-1], fx_w}) - $signed({sx_w[CW-1], sx_w});
            dy1   <= $signed({fy_w[CW-1], fy_w}) - $signed({sy_w[CW-1], sy_w});
            sum1  <= {1'b0, circles.data.first_radius & RAD_MASK}
                   + {1'b0, circles.data.second_radius & RAD_MASK};
            diff1 <= $signed({1'b0, circles.data.first_radius & RAD_MASK})
                   - $signed({1'b0, circles.data.second_radius & RAD_MASK});
        end
    end

    // Stage 2: squares.
    logic signed [2*DW-1:0] dxsq_w, dysq_w;
    logic [SQW-1:0]         sumsq_w;
    logic signed [SQW-1:0]  diffsq_w;
    logic [2*RW-1:0]        r1sq_w, r2sq_w;
    logic [2*DW-2:0]        dx2_2, dy2_2;
    logic [SQW-1:0]         sum2_2, diff2_2;
    logic [2*RW-1:0]        r1sq2, r2sq2;
    logic signed [CW-1:0]   fx2, fy2, sx2, sy2;
    logic [RW-1:0]          r1_2, r2_2;
    logic signed [DW-1:0]   dx2s, dy2s;
    logic                   gt2;

    assign dxsq_w   = dx1 * dx1;
    assign dysq_w   = dy1 * dy1;
    assign sumsq_w  = sum1 * sum1;
    assign diffsq_w = diff1 * diff1;
    assign r1sq_w   = r1_1 * r1_1;
    assign r2sq_w   = r2_1 * r2_1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx2_2   <= dxsq_w[2*DW-2:0];
            dy2_2   <= dysq_w[2*DW-2:0];
            sum2_2  <= sumsq_w;
            diff2_2 <= diffsq_w;
            r1sq2   <= r1sq_w;
            r2sq2   <= r2sq_w;
            fx2     <= fx1;
            fy2     <= fy1;
            sx2     <= sx1;
            sy2     <= sy1;
            r1_2    <= r1_1;
            r2_2    <= r2_1;
            dx2s    <= dx1;
            dy2s    <= dy1;
            gt2     <= r2_1 > r1_1;
        end
    end

    // Stage 3: squared distance and radius term.
    logic [D2W-1:0]           d2_3;
    logic signed [2*RW:0]     ks3;
    logic [SQW-1:0]           sum2_3, diff2_3;
    logic signed [CW-1:0]     fx3, fy3, sx3, sy3;
    logic [RW-1:0]            r1_3, r2_3;
    logic signed [DW-1:0]     dx3, dy3;
    logic                     gt3;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_3    <= {1'b0, dx2_2} + {1'b0, dy2_2};
            ks3     <= $signed({1'b0, r2sq2}) - $signed({1'b0, r1sq2});
            sum2_3  <= sum2_2;
            diff2_3 <= diff2_2;
            fx3     <= fx2;
            fy3     <= fy2;
            sx3     <= sx2;
            sy3     <= sy2;
            r1_3    <= r1_2;
            r2_3    <= r2_2;
            dx3     <= dx2s;
            dy3     <= dy2s;
            gt3     <= gt2;
        end
    end

    // Stage 4: classify the pair and form the radicand factors.
    sq_side_t       side4_w, side4;
    logic [D2W-1:0] a_w, b_w;
    logic [SQW-1:0] a4, b4;

    always_comb
    begin
        side4_w = '0;
        if (d2_3 > {2'b0, sum2_3})
            side4_w.c.cls = CLS_NONE;
        else if (d2_3 > {2'b0, diff2_3})
            side4_w.c.cls = CLS_CROSS;
        else if (gt3 && (d2_3 < {2'b0, diff2_3}))
            side4_w.c.cls = CLS_FIRST;
        else
            side4_w.c.cls = CLS_SECOND;
        if (side4_w.c.cls == CLS_FIRST)
        begin
            side4_w.c.cx = fx3;
            side4_w.c.cy = fy3;
            side4_w.c.cr = r1_3;
        end
        else
        begin
            side4_w.c.cx = sx3;
            side4_w.c.cy = sy3;
            side4_w.c.cr = r2_3;
        end
        side4_w.k  = {{(KW-2*RW-1){ks3[2*RW]}}, ks3} + {{(KW-D2W){1'b0}}, d2_3};
        side4_w.dx = dx3;
        side4_w.dy = dy3;
        side4_w.d2 = d2_3;
        a_w = {2'b0, sum2_3} - d2_3;
        b_w = d2_3 - {2'b0, diff2_3};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4 <= side4_w;
            a4    <= (side4_w.c.cls == CLS_CROSS) ? a_w[SQW-1:0] : '0;
            b4    <= (side4_w.c.cls == CLS_CROSS) ? b_w[SQW-1:0] : '0;
        end
    end

    // Stage 5: radicand.
    logic [PW-1:0] p5;
    sq_side_t      side5;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5    <= a4 * b4;
            side5 <= side4;
        end
    end

    // Square root chain.
    logic [PW-1:0]    rad_w  [SQ_CELLS+1];
    logic [REMW-1:0]  rem_w  [SQ_CELLS+1];
    logic [ROOTW-1:0] root_w [SQ_CELLS+1];
    sq_side_t         sq_side_reg [SQ_CELLS];

    assign rad_w[0]  = p5;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        cci_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (rad_w[i]),
            .rem_in   (rem_w[i]),
            .root_in  (root_w[i]),
            .rad_out  (rad_w[i+1]),
            .rem_out  (rem_w[i+1]),
            .root_out (root_w[i+1])
        );
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                    sq_side_reg[i] <= side5;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (adv)
                    sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // Stage 6: chord products.
    sq_side_t             sd;
    logic signed [NW-1:0] kx_w, ky_w, sxp_w, syp_w;
    logic signed [ROOTW:0] s_w;
    logic signed [NW-1:0] kx6, ky6, sxp6, syp6;
    logic [D2W-1:0]       d2_6;
    ctr_t                 c6;

    assign sd    = sq_side_reg[SQ_CELLS-1];
    assign s_w   = $signed({1'b0, root_w[SQ_CELLS]});
    assign kx_w  = sd.k * sd.dx;
    assign ky_w  = sd.k * sd.dy;
    assign sxp_w = s_w * sd.dx;
    assign syp_w = s_w * sd.dy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kx6  <= kx_w;
            ky6  <= ky_w;
            sxp6 <= sxp_w;
            syp6 <= syp_w;
            d2_6 <= sd.d2;
            c6   <= sd.c;
        end
    end

    // Stage 7: numerators, lanes ordered first x, first y, second x, second y.
    logic signed [NW-1:0] n7 [LANES];
    logic [D2W-1:0]       d2_7;
    ctr_t                 c7;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n7[0] <= kx6 - syp6;
            n7[1] <= ky6 + sxp6;
            n7[2] <= kx6 + syp6;
            n7[3] <= ky6 - sxp6;
            d2_7  <= d2_6;
            c7    <= c6;
        end
    end

    // Stage 8: magnitudes.
    logic [NW-1:0]    mag8 [LANES];
    logic [LANES-1:0] neg8;
    logic [D2W-1:0]   d2_8;
    ctr_t             c8;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                mag8[l] <= n7[l][NW-1] ? -n7[l] : n7[l];
                neg8[l] <= n7[l][NW-1];
            end
            d2_8 <= d2_7;
            c8   <= c7;
        end
    end

    // Stage 9: add half the divisor so the quotient rounds half away from zero.
    logic [NW-1:0] dvd9 [LANES];
    dv_side_t      side9;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
                dvd9[l] <= mag8[l] + {{(NW-D2W){1'b0}}, d2_8};
            side9.den <= {d2_8, 1'b0};
            side9.neg <= neg8;
            side9.c   <= c8;
        end
    end

    // Divider chain, four lanes sharing one divisor.
    logic [DENW-1:0] drem_w  [QW+1][LANES];
    logic [QW-1:0]   dbits_w [QW+1][LANES];
    logic [QW-1:0]   dq_w    [QW+1][LANES];
    dv_side_t        dv_side_reg [QW];
    logic [DENW-1:0] den_w   [QW];

    for (genvar l = 0; l < LANES; l++)
    begin : g_init
        assign drem_w[0][l]  = dvd9[l][NW-1:QW];
        assign dbits_w[0][l] = dvd9[l][QW-1:0];
        assign dq_w[0][l]    = '0;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            assign den_w[j] = side9.den;
            always_ff @(posedge clk)
            begin
                if (adv)
                    dv_side_reg[j] <= side9;
            end
        end
        else
        begin : g_next
            assign den_w[j] = dv_side_reg[j-1].den;
            always_ff @(posedge clk)
            begin
                if (adv)
                    dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            cci_div_cell u_cell (
                .clk      (clk),
                .en       (adv),
                .den      (den_w[j]),
                .rem_in   (drem_w[j][l]),
                .bits_in  (dbits_w[j][l]),
                .q_in     (dq_w[j][l]),
                .rem_out  (drem_w[j+1][l]),
                .bits_out (dbits_w[j+1][l]),
                .q_out    (dq_w[j+1][l])
            );
        end
    end

    // Stage 10: signed offsets from the second centre.
    logic signed [OFFW-1:0] off10 [LANES];
    ctr_t                   c10;
    dv_side_t               dvl;

    assign dvl = dv_side_reg[QW-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
                off10[l] <= dvl.neg[l] ? -$signed({1'b0, dq_w[QW][l]})
                                       : $signed({1'b0, dq_w[QW][l]});
            c10 <= dvl.c;
        end
    end

    // Stage 11: final points, saturated.
    pt_item_t              pt_w, pt11;
    logic signed [PTW-1:0] cx_e, cy_e, cr_e;

    always_comb
    begin
        cx_e       = $signed({{(PTW-CW){c10.cx[CW-1]}}, c10.cx});
        cy_e       = $signed({{(PTW-CW){c10.cy[CW-1]}}, c10.cy});
        cr_e       = $signed({{(PTW-RW){1'b0}}, c10.cr});
        pt_w       = '0;
        pt_w.cls   = c10.cls;
        if (c10.cls == CLS_CROSS)
        begin
            pt_w.x[0] = sat(cx_e + $signed({off10[0][OFFW-1], off10[0]}));
            pt_w.y[0] = sat(cy_e + $signed({off10[1][OFFW-1], off10[1]}));
            pt_w.x[1] = sat(cx_e + $signed({off10[2][OFFW-1], off10[2]}));
            pt_w.y[1] = sat(cy_e + $signed({off10[3][OFFW-1], off10[3]}));
        end
        else
        begin
            pt_w.x[0] = sat(cx_e + cr_e);
            pt_w.y[0] = sat(cy_e);
            pt_w.x[1] = sat(cx_e);
            pt_w.y[1] = sat(cy_e + cr_e);
            pt_w.x[2] = sat(cx_e - cr_e);
            pt_w.y[2] = sat(cy_e);
            pt_w.x[3] = sat(cx_e);
            pt_w.y[3] = sat(cy_e - cr_e);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pt11 <= pt_w;
    end

    // Disjoint pairs are dropped when they reach the sequencer.
    assign adv = !vld_reg[NST-1] || take;

    cci_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (vld_reg[NST-1] && (pt11.cls != CLS_NONE)),
        .item       (pt11),
        .take       (take),
        .points     (points)
    );

`ifndef NO_ASSERTIONS
    a_no_gap_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready && !points.data.last_point |=> points.valid)
        else $error("gap between points of one circle pair");

    a_kind_steady: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready && !points.data.last_point
        |=> points.data.point_kind == $past(points.data.point_kind))
        else $error("point kind changed within one circle pair");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] && !take |=> vld_reg[NST-1] && $stable(pt11))
        else $error("pipeline moved while the sequencer was busy");
`endif

endmodule
